// File: design/first_substring_match_index_core_defines.svh
// assertion macros shared by the first substring match index core
`ifndef FIRST_SUBSTRING_MATCH_INDEX_CORE_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_INDEX_CORE_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define FSMI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define FSMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fsmi_pkg.sv
// types and constants for the first substring match index core
package fsmi_pkg;

  localparam int unsigned PatMaxDef  = 64;
  localparam int unsigned TextMaxDef = 1024;

  localparam int unsigned OpW     = 2;
  localparam int unsigned CharW   = 8;
  localparam int unsigned IdxW    = 11;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned OutUserW = 2;

  // queue depth must be a power of two, pointers wrap freely
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_PAT   = 2'd1,
    OP_TEXT  = 2'd2,
    OP_EOT   = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
  } cmd_t;

endpackage

// File: design/first_substring_match_index_core.sv
// A streaming first-occurrence substring search. Send the pattern with op 1
// beats, then the text with op 2 beats and close it with an op 3 beat, which
// returns the start index of the first match (or all ones with found low).
// The core takes one beat per clock sustained, for every op: a two-entry
// command queue sits in front of the engine and the result sits in an output
// register, so an output stall holds back an end-of-text beat at the queue head
// and stalls input once the queue fills. The figure is set by the engine's
// combinational compare of the whole text window against the pattern. An
// end-of-text beat passes the queue, then the output register. No clearing
// pass is needed after reset; op 0 clears pattern, text, overflow flag at once.
module first_substring_match_index_core import fsmi_pkg::*; #(
  parameter int unsigned PAT_MAX  = PatMaxDef,
  parameter int unsigned TEXT_MAX = TextMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // char_code
  input  logic [OpW-1:0]      s_axis_tuser_i,  // op
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // match_index, zero fill
  output logic [OutUserW-1:0] m_axis_tuser_o   // found, overflow
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  fsmi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop)
  );

  fsmi_back #(
    .PAT_MAX  (PAT_MAX),
    .TEXT_MAX (TEXT_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// File: design/fsmi_front.sv
// input side: accepts beats, decodes the op and queues commands for the engine
module fsmi_front import fsmi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,
  input  logic [OpW-1:0]    s_axis_tuser_i,
  output cmd_t              cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  cmd_t              q_mem [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push, pop;
  cmd_t              cmd_in;

  always_comb begin
    cmd_in.ch = s_axis_tdata_i[CharW-1:0];
    case (s_axis_tuser_i)
      OP_CLEAR: cmd_in.op = OP_CLEAR;
      OP_PAT:   cmd_in.op = OP_PAT;
      OP_TEXT:  cmd_in.op = OP_TEXT;
      default:  cmd_in.op = OP_EOT;
    endcase
  end

  assign s_axis_tready_o = (count_q != QCntW'(QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (count_q != '0);
  assign pop             = cmd_pop_i && cmd_valid_o;
  assign cmd_o           = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: design/fsmi_back.sv
// search engine: pattern and text shift registers, parallel compare, result register
`include "first_substring_match_index_core_defines.svh"

module fsmi_back import fsmi_pkg::*; #(
  parameter int unsigned PAT_MAX  = PatMaxDef,
  parameter int unsigned TEXT_MAX = TextMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  localparam int unsigned LenW  = $clog2(PAT_MAX + 1);
  localparam int unsigned PosW  = $clog2(TEXT_MAX + 1);
  localparam int unsigned CmpW  = (PosW > LenW) ? PosW : LenW;
  localparam int unsigned WideW = (CmpW > IdxW) ? CmpW : IdxW;

  // newest pattern char sits at entry 0, so entry j pairs with window entry j
  logic [CharW-1:0]   pat_q [PAT_MAX];
  logic [PAT_MAX-1:0] pat_vld_q, pat_vld_d;
  logic [LenW-1:0]    pat_len_q, pat_len_d;
  logic [CharW-1:0]   win_q [PAT_MAX];
  logic [CharW-1:0]   win_next [PAT_MAX];
  logic [PosW-1:0]    pos_q, pos_d, pos_next;
  logic [IdxW-1:0]    first_q, first_d;
  logic               match_seen_q, match_seen_d;
  logic               ovf_seen_q, ovf_seen_d;
  logic               out_valid_q, out_valid_d;
  logic [IdxW-1:0]    out_idx_q, out_idx_d;
  logic               out_found_q, out_found_d;
  logic               out_ovf_q, out_ovf_d;
  logic [PAT_MAX-1:0] eq;
  logic               hit;
  logic               pat_room;
  logic               text_room;
  logic               pat_shift, win_shift;
  logic [WideW-1:0]   diff;

  assign cmd_pop_o = cmd_valid_i &&
                     ((cmd_i.op != OP_EOT) || !out_valid_q || m_axis_tready_i);

  assign pos_next  = pos_q + PosW'(1);
  assign pat_room  = (pat_len_q != LenW'(PAT_MAX));
  assign text_room = (pos_q != PosW'(TEXT_MAX));

  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      win_next[j] = (j == 0) ? cmd_i.ch : win_q[(j == 0) ? 0 : j - 1];
      eq[j]       = !pat_vld_q[j] || (pat_q[j] == win_next[j]);
    end
  end

  assign hit  = (&eq) && (CmpW'(pos_next) >= CmpW'(pat_len_q));
  assign diff = WideW'(pos_next) - WideW'(pat_len_q);

  always_comb begin
    pat_vld_d    = pat_vld_q;
    pat_len_d    = pat_len_q;
    pos_d        = pos_q;
    first_d      = first_q;
    match_seen_d = match_seen_q;
    ovf_seen_d   = ovf_seen_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_idx_d    = out_idx_q;
    out_found_d  = out_found_q;
    out_ovf_d    = out_ovf_q;
    pat_shift    = 1'b0;
    win_shift    = 1'b0;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_CLEAR: begin
          pat_vld_d    = '0;
          pat_len_d    = '0;
          pos_d        = '0;
          first_d      = '0;
          match_seen_d = 1'b0;
          ovf_seen_d   = 1'b0;
        end
        OP_PAT: begin
          if (pat_room) begin
            pat_shift = 1'b1;
            pat_vld_d = (pat_vld_q << 1) | PAT_MAX'(1);
            pat_len_d = pat_len_q + LenW'(1);
          end else begin
            ovf_seen_d = 1'b1;
          end
        end
        OP_TEXT: begin
          if (text_room) begin
            win_shift = 1'b1;
            pos_d     = pos_next;
            if (!match_seen_q) begin
              if (pat_len_q == '0) begin
                match_seen_d = 1'b1;
                first_d      = '0;
              end else if (hit) begin
                match_seen_d = 1'b1;
                first_d      = diff[IdxW-1:0];
              end
            end
          end else begin
            ovf_seen_d = 1'b1;
          end
        end
        default: begin
          out_valid_d  = 1'b1;
          out_idx_d    = match_seen_q ? first_q : {IdxW{1'b1}};
          out_found_d  = match_seen_q;
          out_ovf_d    = ovf_seen_q;
          pos_d        = '0;
          first_d      = '0;
          match_seen_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_vld_q    <= '0;
      pat_len_q    <= '0;
      pos_q        <= '0;
      first_q      <= '0;
      match_seen_q <= 1'b0;
      ovf_seen_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pat_vld_q    <= pat_vld_d;
      pat_len_q    <= pat_len_d;
      pos_q        <= pos_d;
      first_q      <= first_d;
      match_seen_q <= match_seen_d;
      ovf_seen_q   <= ovf_seen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_ovf_q   <= out_ovf_d;
    if (pat_shift) begin
      for (int j = 0; j < PAT_MAX; j++) begin
        pat_q[j] <= (j == 0) ? cmd_i.ch : pat_q[(j == 0) ? 0 : j - 1];
      end
    end
    if (win_shift) begin
      for (int j = 0; j < PAT_MAX; j++) begin
        win_q[j] <= win_next[j];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_idx_q);
  assign m_axis_tuser_o  = {out_ovf_q, out_found_q};

  `FSMI_ASSERT_NEXT(a_eot_gives_beat, cmd_pop_o && (cmd_i.op == OP_EOT), out_valid_q, "end of text left no result")
  `FSMI_ASSERT_NOW(a_none_is_all_ones, out_valid_q && !out_found_q, out_idx_q == {IdxW{1'b1}}, "miss without all-ones index")
  `FSMI_ASSERT_NOW(a_match_needs_text, match_seen_q, pos_q != '0, "match latched with no text")
  `FSMI_ASSERT_NEXT(a_stall_holds, out_valid_q && !m_axis_tready_i, out_valid_q && $stable(out_idx_q) && $stable(out_found_q), "pending result changed")

endmodule
